[sv/motor_speed_ramp_with_reverse_brake_macros.svh]
// assertion macros shared by the speed ramp checker
// no dependencies; included by the checker file
`ifndef MOTOR_SPEED_RAMP_WITH_REVERSE_BRAKE_MACROS_SVH
`define MOTOR_SPEED_RAMP_WITH_REVERSE_BRAKE_MACROS_SVH

// same-cycle implication, disabled during reset
`define MSR_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define MSR_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/msr_pkg.sv]
// shared types, constants and helpers of the speed ramp block
// no dependencies; imported by every module of the block
`default_nettype none

package msr_pkg;

    localparam int SPEED_W  = 11;
    localparam int TARGET_W = 16;
    localparam int STEP_W   = 8;
    localparam int CYCLE_W  = 7;
    localparam int BRAKE_W  = 10;
    localparam int ELAPSED_W = 11;
    localparam int INDEX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic signed [SPEED_W-1:0]  SPEED_LIMIT = 11'sd1000;
    localparam logic signed [TARGET_W-1:0] TARGET_HI   = 16'sd1000;
    localparam logic signed [TARGET_W-1:0] TARGET_LO   = -16'sd1000;

    localparam logic [STEP_W-1:0] STEP_MIN = 8'd10;
    localparam logic [STEP_W-1:0] STEP_MAX = 8'd200;

    localparam logic [STEP_W-1:0]  SLEW_LIMIT_RST = 8'd50;
    localparam logic [CYCLE_W-1:0] CYCLE_MS_RST   = 7'd10;
    localparam logic [BRAKE_W-1:0] BRAKE_MS_RST   = 10'd50;

    // register indexes on the config port
    localparam logic [INDEX_W-1:0] REG_SLEW_LIMIT = 2'd0;
    localparam logic [INDEX_W-1:0] REG_CYCLE_MS   = 2'd1;
    localparam logic [INDEX_W-1:0] REG_BRAKE_MS   = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_BRAKE,
        PH_HOLD,
        PH_RESUME
    } brake_phase_t;

    typedef struct packed {
        logic [STEP_W-1:0]  slew_limit;
        logic [CYCLE_W-1:0] cycle_ms;
        logic [BRAKE_W-1:0] brake_ms;
    } cfg_t;

    typedef struct packed {
        logic                       mode;
        logic signed [TARGET_W-1:0] target;
    } in_item_t;

    typedef struct packed {
        logic                      settled;
        logic signed [SPEED_W-1:0] speed;
    } out_item_t;

    // limit a raw target to the speed range
    function automatic logic signed [SPEED_W-1:0] clamp_target(
        input logic signed [TARGET_W-1:0] raw
    );
        logic signed [SPEED_W-1:0] res;
        if (raw > TARGET_HI)
            res = SPEED_LIMIT;
        else if (raw < TARGET_LO)
            res = -SPEED_LIMIT;
        else
            res = raw[SPEED_W-1:0];
        return res;
    endfunction

endpackage

`default_nettype wire

[sv/msr_cfg.sv]
// configuration registers of the speed ramp block
// depends on msr_pkg
`default_nettype none

module msr_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [msr_pkg::INDEX_W-1:0]    cfg_index,
    input  wire logic [msr_pkg::CFG_DATA_W-1:0] cfg_data,
    output msr_pkg::cfg_t                       cfg
);
    import msr_pkg::*;

    logic [STEP_W-1:0]  slew_limit_reg;
    logic [CYCLE_W-1:0] cycle_ms_reg;
    logic [BRAKE_W-1:0] brake_ms_reg;
    logic [STEP_W-1:0]  step_raw;
    logic [STEP_W-1:0]  step_sat;

    // writes are always accepted
    assign cfg_ready = 1'b1;

    // slew limit saturates into its legal range
    assign step_raw = cfg_data[STEP_W-1:0];
    always_comb
    begin
        if (step_raw < STEP_MIN)
            step_sat = STEP_MIN;
        else if (step_raw > STEP_MAX)
            step_sat = STEP_MAX;
        else
            step_sat = step_raw;
    end

    // register file, unknown indexes dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slew_limit_reg <= SLEW_LIMIT_RST;
            cycle_ms_reg   <= CYCLE_MS_RST;
            brake_ms_reg   <= BRAKE_MS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SLEW_LIMIT: slew_limit_reg <= step_sat;
                REG_CYCLE_MS:   cycle_ms_reg   <= cfg_data[CYCLE_W-1:0];
                REG_BRAKE_MS:   brake_ms_reg   <= cfg_data[BRAKE_W-1:0];
                default:        ;
            endcase
        end
    end

    assign cfg.slew_limit = slew_limit_reg;
    assign cfg.cycle_ms   = cycle_ms_reg;
    assign cfg.brake_ms   = brake_ms_reg;

endmodule

`default_nettype wire

[sv/msr_in_stage.sv]
// input register of the speed ramp block
// depends on msr_pkg
`default_nettype none

module msr_in_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire msr_pkg::in_item_t s_item,
    input  wire logic              take,
    output logic                   item_valid,
    output msr_pkg::in_item_t      item
);
    import msr_pkg::*;

    logic     valid_reg;
    in_item_t item_reg;

    // room when empty or when the held word leaves this cycle
    assign s_tready = !valid_reg || take;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (s_tready)
            valid_reg <= s_tvalid;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            item_reg <= s_item;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

[sv/msr_core.sv]
// ramp and brake-before-reverse state machine of the speed ramp block
// depends on msr_pkg
`default_nettype none

module msr_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              fire,
    input  wire msr_pkg::in_item_t item,
    input  wire msr_pkg::cfg_t     cfg,
    output msr_pkg::out_item_t     res
);
    import msr_pkg::*;

    logic signed [SPEED_W-1:0] speed_reg, speed_next;
    logic signed [SPEED_W-1:0] held_reg, held_next;
    brake_phase_t              phase_reg, phase_next;
    logic [ELAPSED_W-1:0]      elapsed_reg, elapsed_next;
    logic                      rev_reg, rev_next;

    logic signed [SPEED_W-1:0] goal;
    logic                      rev_start;
    logic                      rev_now;
    brake_phase_t              phase_cur;
    logic [ELAPSED_W-1:0]      elapsed_cur;
    logic [ELAPSED_W-1:0]      elapsed_sum;
    logic                      braking;
    logic signed [SPEED_W-1:0] ramp_goal;
    logic signed [SPEED_W:0]   delta;
    logic [SPEED_W:0]          delta_abs;
    logic signed [SPEED_W:0]   step_s;
    logic signed [SPEED_W:0]   moved;
    logic                      near;
    logic signed [SPEED_W-1:0] ramped;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg   <= '0;
            held_reg    <= '0;
            phase_reg   <= PH_IDLE;
            elapsed_reg <= '0;
            rev_reg     <= 1'b0;
        end
        else if (fire)
        begin
            speed_reg   <= speed_next;
            held_reg    <= held_next;
            phase_reg   <= phase_next;
            elapsed_reg <= elapsed_next;
            rev_reg     <= rev_next;
        end
    end

    // reversal detect: target of opposite sign to a moving motor
    assign goal      = clamp_target(item.target);
    assign rev_start = !rev_reg &&
                       ((speed_reg > 0 && goal < 0) || (speed_reg < 0 && goal > 0));
    assign rev_now     = rev_reg || rev_start;
    assign phase_cur   = rev_start ? PH_BRAKE : phase_reg;
    assign elapsed_cur = rev_start ? '0 : elapsed_reg;
    assign elapsed_sum = elapsed_cur + {{(ELAPSED_W-CYCLE_W){1'b0}}, cfg.cycle_ms};

    // shared slew unit: toward zero while braking, else toward the target
    assign braking   = rev_now && (phase_cur == PH_BRAKE);
    assign ramp_goal = braking ? '0 : goal;
    assign delta     = {ramp_goal[SPEED_W-1], ramp_goal} - {speed_reg[SPEED_W-1], speed_reg};
    assign delta_abs = delta[SPEED_W] ? $unsigned(-delta) : $unsigned(delta);
    assign step_s    = $signed({{(SPEED_W+1-STEP_W){1'b0}}, cfg.slew_limit});
    assign near      = delta_abs <= {{(SPEED_W+1-STEP_W){1'b0}}, cfg.slew_limit};
    assign moved     = delta[SPEED_W] ? ({speed_reg[SPEED_W-1], speed_reg} - step_s)
                                      : ({speed_reg[SPEED_W-1], speed_reg} + step_s);
    assign ramped    = near ? ramp_goal : moved[SPEED_W-1:0];

    // next state
    always_comb
    begin
        speed_next   = speed_reg;
        held_next    = goal;
        phase_next   = phase_reg;
        elapsed_next = elapsed_reg;
        rev_next     = rev_reg;
        if (item.mode)
        begin
            speed_next   = '0;
            held_next    = '0;
            phase_next   = PH_IDLE;
            elapsed_next = '0;
            rev_next     = 1'b0;
        end
        else if (rev_now)
        begin
            case (phase_cur)
                PH_BRAKE:
                begin
                    speed_next   = ramped;
                    rev_next     = 1'b1;
                    elapsed_next = near ? '0 : elapsed_cur;
                    phase_next   = near ? PH_HOLD : PH_BRAKE;
                end
                PH_HOLD:
                begin
                    rev_next     = 1'b1;
                    elapsed_next = elapsed_sum;
                    if (elapsed_sum >= {1'b0, cfg.brake_ms})
                    begin
                        phase_next = PH_RESUME;
                        speed_next = ramped;
                    end
                    else
                    begin
                        phase_next = PH_HOLD;
                    end
                end
                default:
                begin
                    rev_next     = 1'b0;
                    phase_next   = PH_IDLE;
                    elapsed_next = elapsed_cur;
                    speed_next   = ramped;
                end
            endcase
        end
        else
        begin
            speed_next = ramped;
        end
    end

    // result of this tick
    assign res.speed   = speed_next;
    assign res.settled = (speed_next == held_next) && !rev_next;

endmodule

`default_nettype wire

[sv/msr_out_stage.sv]
// output register of the speed ramp block
// depends on msr_pkg
`default_nettype none

module msr_out_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  wire msr_pkg::out_item_t res,
    output logic                    free,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output msr_pkg::out_item_t      m_item
);
    import msr_pkg::*;

    logic      valid_reg;
    out_item_t item_reg;

    // a new word may land when empty or when the held one is taken
    assign free = !valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (free)
            valid_reg <= load;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= res;
    end

    assign m_tvalid = valid_reg;
    assign m_item   = item_reg;

endmodule

`default_nettype wire

[sv/motor_speed_ramp_with_reverse_brake.sv]
// Motor speed ramp with brake-before-reverse, one control tick per input word.
// Slave stream: s_tdata carries the signed target, s_tuser the mode
// (0 ramp toward target, 1 emergency stop). Master stream: m_tdata carries
// the smoothed signed speed and the settled flag.
// Config channel: cfg_index 0 slew limit (saturated to 10..200), 1 cycle_ms,
// 2 brake_ms; other indexes are ignored. cfg_ready is always high; write
// only while no word is in flight.
// Path: an accepted word waits in the input register until the master side is
// free, then passes into the output register, where m_tvalid rises.
// Throughput: one word per clock while m_tready stays high; the whole tick is
// one pass from the input register through the slew unit and the brake state
// machine into the output register.
// Reset: speed, held target, brake phase, timer and reversal flag clear,
// registers return to 50 / 10 / 50, both stream registers empty.
// Stall: while m_tready is low the result word holds; one more word can sit
// in the input register, after which s_tready drops.
// Depends on msr_pkg, msr_cfg, msr_in_stage, msr_core, msr_out_stage.
`default_nettype none

module motor_speed_ramp_with_reverse_brake (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [15:0]                    s_tdata,   // [15:0] target
    input  wire logic [0:0]                     s_tuser,   // [0] mode
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [15:0]                         m_tdata,   // [10:0] speed, [11] settled
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [msr_pkg::INDEX_W-1:0]    cfg_index,
    input  wire logic [msr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import msr_pkg::*;

    cfg_t      cfg;
    in_item_t  s_item;
    in_item_t  item;
    out_item_t res;
    out_item_t m_item;
    logic      item_valid;
    logic      out_free;
    logic      fire;

    assign s_item.mode   = s_tuser[0];
    assign s_item.target = $signed(s_tdata);

    // a tick runs when a word waits and the output register has room
    assign fire = item_valid && out_free;

    msr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    msr_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .take       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    msr_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item),
        .cfg   (cfg),
        .res   (res)
    );

    msr_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (fire),
        .res      (res),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_item   (m_item)
    );

    // pack the result word, zero fill to 16 bits
    assign m_tdata = {4'b0000, m_item.settled, m_item.speed};

endmodule

`default_nettype wire

[sv/msr_checker.sv]
// port-level checks of the speed ramp block, bound to the top level
// depends on msr_pkg and the macro header
`default_nettype none

`include "motor_speed_ramp_with_reverse_brake_macros.svh"

module msr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata
);
    import msr_pkg::*;

    logic signed [SPEED_W-1:0] speed_out;
    logic                      speed_ok;
    logic                      in_hs;
    logic                      out_room;

    assign speed_out = $signed(m_tdata[SPEED_W-1:0]);
    assign speed_ok  = (speed_out <= SPEED_LIMIT) && (speed_out >= -SPEED_LIMIT);
    assign in_hs     = s_tvalid && s_tready;
    assign out_room  = m_tready || !m_tvalid;

    // the slew unit never leaves the speed range
    `MSR_ASSERT_IMPLY(a_speed_range, clk, rst_n, m_tvalid, speed_ok, "speed out of range")

    // an accepted word reaches the output register once that register has room
    `MSR_ASSERT_NEXT(a_latency, clk, rst_n, in_hs ##1 out_room, m_tvalid, "result word missing")

    // a stalled result word holds
    `MSR_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled word changed")

endmodule

bind motor_speed_ramp_with_reverse_brake msr_checker u_msr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
